FILE: src/assert_macros.svh
// assertion macros shared by the deframer rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: src/mlfd_pkg.sv
`timescale 1ns / 1ps
// types and constants of the magic/length frame deframer
// no dependencies
package mlfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAGIC_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAGIC_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH   = 2'd2;

  // configuration reset values
  localparam logic [ByteW-1:0] MAGIC_FIRST_RST  = 8'h36;
  localparam logic [ByteW-1:0] MAGIC_SECOND_RST = 8'h50;
  localparam logic [ByteW-1:0] MAX_LENGTH_RST   = 8'd253;

  // result kinds
  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_HEARTBEAT = 3'd1,
    KIND_HDR_ERR   = 3'd2,
    KIND_LEN_ERR   = 3'd3,
    KIND_EMPTY     = 3'd4
  } kind_e;

  // one result transaction
  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic             last;
  } result_t;

endpackage

FILE: src/magic_length_frame_deframer_unit.sv
`timescale 1ns / 1ps
// magic/length frame deframer: header hunt, length check, payload streaming
// depends on mlfd_pkg and assert_macros.svh
//
// Usage
//   Input channel: one received byte per transaction (rx_byte_i), taken at a
//   clock edge with in_valid_i high and in_stall_o low.
//   Output channel: zero or one result per input byte (out_kind_o,
//   out_byte_o, frame_last_o), taken at an edge with out_valid_o high and
//   out_stall_i low.
//   Configuration: cfg_we_i writes cfg_data_i into the register chosen by
//   cfg_index_i (magic first, magic second, maximum length); write only
//   while the block is idle. Other indexes are ignored.
//   Each result is registered: in the skid register if the output is stalled.
//   Throughput: one byte per cycle while in_stall_o is low; the parse step
//   is a single pass of logic between the parser state and the result register.
//   Stall: a two-entry result queue (output register plus skid register)
//   keeps bytes flowing under output stall until the skid register fills;
//   in_stall_o is raised only while the skid register holds a result.
//   Reset: parser hunts for the first header byte, queue empty, registers
//   return to 0x36, 0x50 and 253.
module magic_length_frame_deframer_unit
  import mlfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_kind_o,
  output logic [ByteW-1:0]   out_byte_o,
  output logic               frame_last_o,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i
);

`include "assert_macros.svh"

  typedef enum logic [1:0] {
    PH_HUNT1   = 2'd0,
    PH_HUNT2   = 2'd1,
    PH_LEN     = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_e;

  // configuration registers
  logic [ByteW-1:0] magic_first_q, magic_second_q, max_len_q;

  // parser state
  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] rem_q, rem_d;
  logic             hb_q, hb_d;
  logic             await_q, await_d;

  // result queue
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;

  // step outputs
  logic             res_valid;
  result_t          res;
  logic             hb_cur;
  logic [ByteW-1:0] rem_dec;
  logic             in_take, out_take;

  assign in_take  = in_valid_i & ~skid_valid_q;
  assign out_take = out_valid_q & ~out_stall_i;
  assign hb_cur   = await_q ? (rx_byte_i == '0) : hb_q;
  assign rem_dec  = rem_q - ByteW'(1);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_first_q  <= MAGIC_FIRST_RST;
      magic_second_q <= MAGIC_SECOND_RST;
      max_len_q      <= MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAGIC_FIRST:  magic_first_q  <= cfg_data_i;
        CFG_MAGIC_SECOND: magic_second_q <= cfg_data_i;
        CFG_MAX_LENGTH:   max_len_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // one parse step per byte
  always_comb begin
    phase_d   = phase_q;
    rem_d     = rem_q;
    hb_d      = hb_q;
    await_d   = await_q;
    res_valid = 1'b0;
    res.kind  = KIND_PAYLOAD;
    res.data  = '0;
    res.last  = 1'b0;
    unique case (phase_q)
      PH_HUNT1: begin
        if (rx_byte_i == magic_first_q) begin
          phase_d = PH_HUNT2;
        end else begin
          res_valid = 1'b1;
          res.kind  = KIND_HDR_ERR;
        end
      end
      PH_HUNT2: begin
        if (rx_byte_i == magic_second_q) begin
          phase_d = PH_LEN;
        end else begin
          phase_d   = PH_HUNT1;
          res_valid = 1'b1;
          res.kind  = KIND_HDR_ERR;
        end
      end
      PH_LEN: begin
        phase_d = PH_HUNT1;
        if (rx_byte_i > max_len_q) begin
          res_valid = 1'b1;
          res.kind  = KIND_LEN_ERR;
        end else if (rx_byte_i == '0) begin
          res_valid = 1'b1;
          res.kind  = KIND_EMPTY;
        end else begin
          rem_d   = rx_byte_i;
          await_d = 1'b1;
          hb_d    = 1'b0;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        await_d = 1'b0;
        rem_d   = rem_dec;
        if (rem_dec == '0) begin
          // final byte of the frame
          phase_d   = PH_HUNT1;
          hb_d      = 1'b0;
          res_valid = 1'b1;
          if (hb_cur) begin
            res.kind = KIND_HEARTBEAT;
          end else begin
            res.data = rx_byte_i;
            res.last = 1'b1;
          end
        end else begin
          hb_d = hb_cur;
          if (!hb_cur) begin
            res_valid = 1'b1;
            res.data  = rx_byte_i;
          end
        end
      end
      default: ;
    endcase
  end

  // parser state and result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT1;
      rem_q        <= '0;
      hb_q         <= 1'b0;
      await_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        phase_q <= phase_d;
        rem_q   <= rem_d;
        hb_q    <= hb_d;
        await_q <= await_d;
      end
      if (skid_valid_q) begin
        // no byte is taken while the skid register is full
        if (out_take) begin
          out_q        <= skid_q;
          skid_valid_q <= 1'b0;
        end
      end else if (in_take && res_valid) begin
        if (!out_valid_q || out_take) begin
          out_q       <= res;
          out_valid_q <= 1'b1;
        end else begin
          skid_q       <= res;
          skid_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o   = skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_q.kind;
  assign out_byte_o   = out_q.data;
  assign frame_last_o = out_q.last;

  // checks
  `ASSERT_IMPLY(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q,
                "skid register full while output register empty")
  `ASSERT_IMPLY(a_last_is_payload, clk_i, rst_ni, out_valid_q && out_q.last,
                out_q.kind == KIND_PAYLOAD, "frame end marked on a non-payload result")
  `ASSERT_IMPLY(a_byte_zero, clk_i, rst_ni, out_valid_q && out_q.kind != KIND_PAYLOAD,
                out_q.data == '0, "non-payload result carries a byte")
  `ASSERT_IMPLY(a_payload_count, clk_i, rst_ni, phase_q == PH_PAYLOAD, rem_q != '0,
                "payload phase with no bytes left")
  `ASSERT_IMPLY(a_type_in_payload, clk_i, rst_ni, await_q, phase_q == PH_PAYLOAD,
                "type byte awaited outside the payload phase")
  `ASSERT_ALWAYS(a_stall_blocks_take, clk_i, rst_ni, !(skid_valid_q && in_take),
                 "byte taken while the skid register is full")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of magic_length_frame_deframer_unit
// depends on mlfd_pkg and the deframer rtl; predicts every result on its own

// parser phases of the predictor
typedef enum logic [1:0] {
  SEEK_FIRST,
  SEEK_SECOND,
  READ_LENGTH,
  READ_PAYLOAD
} seek_phase_e;

// predicts the results of the deframer and matches them in order
class deframe_scoreboard;
  logic [7:0]          magic_first;
  logic [7:0]          magic_second;
  logic [7:0]          max_length;
  seek_phase_e         phase;
  logic [7:0]          remaining;
  bit                  heartbeat;
  bit                  type_pending;
  mlfd_pkg::result_t   awaited_results[$];
  int unsigned         errors;

  function new();
    magic_first  = mlfd_pkg::MAGIC_FIRST_RST;
    magic_second = mlfd_pkg::MAGIC_SECOND_RST;
    max_length   = mlfd_pkg::MAX_LENGTH_RST;
    phase        = SEEK_FIRST;
    remaining    = 8'd0;
    heartbeat    = 1'b0;
    type_pending = 1'b0;
    errors       = 0;
  endfunction

  function void write_register(input logic [1:0] index, input logic [7:0] value);
    case (index)
      mlfd_pkg::CFG_MAGIC_FIRST:  magic_first  = value;
      mlfd_pkg::CFG_MAGIC_SECOND: magic_second = value;
      mlfd_pkg::CFG_MAX_LENGTH:   max_length   = value;
      default: ;
    endcase
  endfunction

  // advance the parser by one accepted byte transaction
  function void note_byte(input logic [7:0] b);
    mlfd_pkg::result_t r;
    bit                give;
    give   = 1'b0;
    r.kind = mlfd_pkg::KIND_HDR_ERR;
    r.data = 8'h00;
    r.last = 1'b0;
    case (phase)
      SEEK_SECOND: begin
        if (b == magic_second) begin
          phase = READ_LENGTH;
        end else begin
          phase = SEEK_FIRST;
          give  = 1'b1;
        end
      end
      READ_LENGTH: begin
        phase = SEEK_FIRST;
        if (b > max_length) begin
          give   = 1'b1;
          r.kind = mlfd_pkg::KIND_LEN_ERR;
        end else if (b == 8'd0) begin
          give   = 1'b1;
          r.kind = mlfd_pkg::KIND_EMPTY;
        end else begin
          remaining    = b;
          type_pending = 1'b1;
          heartbeat    = 1'b0;
          phase        = READ_PAYLOAD;
        end
      end
      READ_PAYLOAD: begin
        // the first payload byte decides whether the frame is a heartbeat
        if (type_pending) begin
          heartbeat    = (b == 8'd0);
          type_pending = 1'b0;
        end
        remaining = remaining - 8'd1;
        if (remaining == 8'd0) begin
          phase = SEEK_FIRST;
          give  = 1'b1;
          if (heartbeat) begin
            r.kind = mlfd_pkg::KIND_HEARTBEAT;
          end else begin
            r.kind = mlfd_pkg::KIND_PAYLOAD;
            r.data = b;
            r.last = 1'b1;
          end
          heartbeat = 1'b0;
        end else if (!heartbeat) begin
          give   = 1'b1;
          r.kind = mlfd_pkg::KIND_PAYLOAD;
          r.data = b;
        end
      end
      default: begin
        if (b == magic_first) begin
          phase = SEEK_SECOND;
        end else begin
          give = 1'b1;
        end
      end
    endcase
    if (give) begin
      awaited_results.push_back(r);
    end
  endfunction

  // compare one result transaction with the oldest prediction
  function void check_result(input mlfd_pkg::result_t got);
    mlfd_pkg::result_t want;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, got kind %0d byte %0d last %0d",
               $time, got.kind, got.data, got.last);
      errors++;
      return;
    end
    want = awaited_results.pop_front();
    if (got.kind != want.kind) begin
      $display("%0t: kind mismatch: expected %0d, got %0d", $time, want.kind, got.kind);
      errors++;
    end
    if (got.data != want.data) begin
      $display("%0t: byte mismatch: expected %0d, got %0d", $time, want.data, got.data);
      errors++;
    end
    if (got.last != want.last) begin
      $display("%0t: frame_last mismatch: expected %0d, got %0d",
               $time, want.last, got.last);
      errors++;
    end
  endfunction
endclass

module testbench;
  import mlfd_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [ByteW-1:0]   rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_kind;
  logic [ByteW-1:0]   out_byte;
  logic               frame_last;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ByteW-1:0]   cfg_data;

  deframe_scoreboard board;
  bit                calm;
  int unsigned       bytes_sent;
  int unsigned       quiet_cycles;

  magic_length_frame_deframer_unit u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_kind_o   (out_kind),
    .out_byte_o   (out_byte),
    .frame_last_o (frame_last),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  // clock
  always #6 clk = ~clk;

  // send one byte transaction after a random gap
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= value;
    do @(posedge clk); while (in_stall);
    board.note_byte(value);
    bytes_sent++;
  endtask

  // stop sending and wait until every predicted result has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (board.awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_register(input logic [CfgIdxW-1:0] index, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    board.write_register(index, value);
  endtask

  // length byte: mostly short frames, some empty, at the limit or over it
  function automatic logic [7:0] pick_length();
    int unsigned roll;
    int unsigned top;
    roll = $urandom_range(0, 99);
    top  = 32'(board.max_length);
    if (roll < 6) begin
      return 8'd0;
    end else if (roll < 14) begin
      return (top < 255) ? 8'($urandom_range(top + 1, 255)) : 8'(top);
    end else if (roll < 17) begin
      return 8'(top);
    end else if (top == 0) begin
      return 8'd0;
    end
    return 8'($urandom_range(1, (top < 12) ? top : 12));
  endfunction

  // one random piece of stream: mostly frames, some noise and broken headers
  task automatic send_frame();
    int unsigned pick;
    int unsigned len;
    int unsigned i;
    pick = $urandom_range(0, 99);
    calm = ($urandom_range(0, 5) == 0);
    if (pick < 10) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 18) begin
      send_byte(board.magic_first);
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      len = 32'(pick_length());
      send_byte(board.magic_first);
      send_byte(board.magic_second);
      send_byte(8'(len));
      if (len <= board.max_length) begin
        for (i = 0; i < len; i++) begin
          if (i == 0 && $urandom_range(0, 3) == 0) begin
            send_byte(8'd0);
          end else begin
            send_byte(8'($urandom_range(0, 255)));
          end
        end
      end
    end
  endtask

  // reprogram the registers while idle, then run random stream
  task automatic run_setting(input logic [7:0] first, input logic [7:0] second,
                             input logic [7:0] max_len, input int unsigned count);
    int unsigned target;
    settle();
    put_register(CFG_UNUSED, 8'($urandom_range(0, 255)));
    put_register(CFG_MAGIC_FIRST, first);
    put_register(CFG_MAGIC_SECOND, second);
    put_register(CFG_MAX_LENGTH, max_len);
    cfg_we <= 1'b0;
    target = bytes_sent + count;
    while (bytes_sent < target) send_frame();
  endtask

  // output side: random stall before each result transaction
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 4);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = kind_e'(out_kind);
      got.data = out_byte;
      got.last = frame_last;
      board.check_result(got);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // main sequence
  initial begin
    logic [7:0] directed_bytes [25];
    int unsigned i;
    directed_bytes = '{
      // mismatching bytes while hunting
      8'h00, 8'hFF,
      // wrong second header byte
      MAGIC_FIRST_RST, 8'h51,
      // empty frame
      MAGIC_FIRST_RST, MAGIC_SECOND_RST, 8'h00,
      // length one over the limit
      MAGIC_FIRST_RST, MAGIC_SECOND_RST, 8'hFE,
      // one-byte heartbeat
      MAGIC_FIRST_RST, MAGIC_SECOND_RST, 8'h01, 8'h00,
      // longer heartbeat
      MAGIC_FIRST_RST, MAGIC_SECOND_RST, 8'h03, 8'h00, 8'hAA, 8'hFF,
      // data frame
      MAGIC_FIRST_RST, MAGIC_SECOND_RST, 8'h02, 8'h80, 8'hFF
    };
    board        = new();
    calm         = 1'b0;
    bytes_sent   = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    rx_byte      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed stream at the reset register values
    for (i = 0; i < 25; i++) begin
      calm = ($urandom_range(0, 2) == 0);
      send_byte(directed_bytes[i]);
    end

    run_setting(MAGIC_FIRST_RST, MAGIC_SECOND_RST, MAX_LENGTH_RST, 220);
    run_setting(8'h00, 8'hFF, 8'h00, 150);
    run_setting(8'hFF, 8'h00, 8'hFF, 260);
    run_setting(8'hA5, 8'hA5, 8'd6, 220);
    run_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(1, 16)), 220);
    run_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 220);

    settle();
    board.errors += board.awaited_results.size();
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/mlfd_pkg.sv
src/magic_length_frame_deframer_unit.sv
test/testbench.sv
